@@ rtl/core/bdlp_pkg.sv @@
// Shared types and constants for the button debouncer with long-press detection and beeper.
// Used by bdlp_step and button_debounce_long_press_beeper. No dependencies.
`default_nettype none

package bdlp_pkg;

    localparam int STABLE_SAMPLES_DEF = 4;

    localparam int HOLD_W = 16;
    localparam int TICK_W = 10;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [TICK_W-1:0] TICK_PERIOD_RST = TICK_W'(10);
    localparam logic [HOLD_W-1:0] LONG_PRESS_RST = HOLD_W'(1000);
    localparam logic [HOLD_W-1:0] HOLD_CONTINUE_LIMIT = HOLD_W'(60000);
    localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_TICK_PERIOD = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS = CFG_ADDR_W'(1);

    // Item kinds carried on s_tuser.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BEEP = 1'b1;

    typedef struct packed {
        logic              pressed;
        logic              long_done;
        logic [HOLD_W-1:0] hold_count;
        logic [HOLD_W-1:0] last_hold;
        logic [HOLD_W-1:0] beep_left;
        logic              buzzer;
    } ctrl_state_t;

    // Packed so that is_pressed sits in the lowest bit.
    typedef struct packed {
        logic              buzzer_on;
        logic [HOLD_W-1:0] released_hold_ms;
        logic              release_event;
        logic              long_event;
        logic              short_event;
        logic [HOLD_W-1:0] hold_time_ms;
        logic              is_pressed;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

@@ rtl/core/button_debounce_long_press_beeper.sv @@
// Top level of the button debouncer with long-press detection and timed beeper.
// Depends on bdlp_pkg and bdlp_step.
//
//  Channel  | Direction | Payload
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser: action; tdata: raw_level, beep_duration_ms
//  m_axis   | out       | tdata: is_pressed .. buzzer_on (one result per item)
//  cfg      | in        | cfg_addr: register index; cfg_data: value
//
// One item is taken per clock cycle while a stalled m_tready does not hold the block.
// An item moves from the input register into the result register, and its result is
// offered on m_axis from the result register.
// The single state update per item, computed by bdlp_step, allows that rate.
// aresetn is synchronous and active low; it clears the item state to zero and
// returns the configuration registers to their defaults.
// A stalled m_tready holds the result register, then the input register.
`default_nettype none

module button_debounce_long_press_beeper #(
    parameter int STABLE_SAMPLES = bdlp_pkg::STABLE_SAMPLES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [23:0]                       s_tdata,  // raw_level, beep_duration_ms, pad
    input  wire logic                              s_tuser,  // action
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // is_pressed, hold_time_ms, short_event, long_event, release_event,
    // released_hold_ms, buzzer_on, pad
    output logic [39:0]                            m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bdlp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [bdlp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                               in_valid_reg;
    logic                               in_action_reg;
    logic                               in_raw_reg;
    logic [bdlp_pkg::HOLD_W-1:0]        in_dur_reg;
    logic                               out_valid_reg;
    bdlp_pkg::result_t                  out_reg;
    logic [STABLE_SAMPLES-1:0]          hist_reg;
    logic [STABLE_SAMPLES-1:0]          hist_next;
    bdlp_pkg::ctrl_state_t              st_reg;
    bdlp_pkg::ctrl_state_t              st_next;
    bdlp_pkg::result_t                  result_next;
    logic [bdlp_pkg::TICK_W-1:0]        tick_period_reg;
    logic [bdlp_pkg::HOLD_W-1:0]        long_press_reg;
    logic                               advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = {(40 - bdlp_pkg::RESULT_W)'(0), out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg <= bdlp_pkg::TICK_PERIOD_RST;
            long_press_reg <= bdlp_pkg::LONG_PRESS_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_addr == bdlp_pkg::CFG_TICK_PERIOD) begin
                tick_period_reg <= cfg_data[bdlp_pkg::TICK_W-1:0];
            end else if (cfg_addr == bdlp_pkg::CFG_LONG_PRESS) begin
                long_press_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_action_reg <= s_tuser;
            in_raw_reg <= s_tdata[0];
            in_dur_reg <= s_tdata[16:1];
        end
    end

    bdlp_step #(
        .STABLE_SAMPLES(STABLE_SAMPLES)
    ) u_step (
        .action          (in_action_reg),
        .raw_level       (in_raw_reg),
        .beep_duration_ms(in_dur_reg),
        .tick_period_ms  (tick_period_reg),
        .long_press_ms   (long_press_reg),
        .hist            (hist_reg),
        .st              (st_reg),
        .hist_next       (hist_next),
        .st_next         (st_next),
        .result          (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
            st_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                hist_reg <= hist_next;
                st_reg <= st_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    // A press cannot end both as a short and as a long press.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_reg.short_event && out_reg.long_event))
        else $error("short and long event in the same result");

    // A short event only comes with the release that ends the press.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.short_event) |-> out_reg.release_event)
        else $error("short event without release event");

    // After a release the debounced state must read as not pressed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.release_event) |-> !out_reg.is_pressed)
        else $error("release event while still pressed");

    // A stalled result must not be overwritten by a new one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

@@ rtl/core/bdlp_step.sv @@
// Next-state and result logic for one item of the debouncer and beeper.
// Depends on bdlp_pkg.
`default_nettype none

module bdlp_step #(
    parameter int STABLE_SAMPLES = bdlp_pkg::STABLE_SAMPLES_DEF
) (
    input  wire logic                            action,
    input  wire logic                            raw_level,
    input  wire logic [bdlp_pkg::HOLD_W-1:0]     beep_duration_ms,
    input  wire logic [bdlp_pkg::TICK_W-1:0]     tick_period_ms,
    input  wire logic [bdlp_pkg::HOLD_W-1:0]     long_press_ms,
    input  wire logic [STABLE_SAMPLES-1:0]       hist,
    input  wire bdlp_pkg::ctrl_state_t           st,
    output logic      [STABLE_SAMPLES-1:0]       hist_next,
    output bdlp_pkg::ctrl_state_t                st_next,
    output bdlp_pkg::result_t                    result
);

    logic [STABLE_SAMPLES-1:0] shifted;
    logic [bdlp_pkg::HOLD_W:0] hold_sum;
    logic [bdlp_pkg::HOLD_W-1:0] hold_sat;
    logic [bdlp_pkg::HOLD_W-1:0] tick_ext;
    logic ev_short;
    logic ev_long;
    logic ev_release;

    assign shifted = {hist[STABLE_SAMPLES-2:0], raw_level};
    assign tick_ext = bdlp_pkg::HOLD_W'(tick_period_ms);
    assign hold_sum = {1'b0, st.hold_count} + {1'b0, tick_ext};
    assign hold_sat = hold_sum[bdlp_pkg::HOLD_W] ? bdlp_pkg::HOLD_MAX
                                                 : hold_sum[bdlp_pkg::HOLD_W-1:0];

    always_comb begin
        hist_next = hist;
        st_next = st;
        ev_short = 1'b0;
        ev_long = 1'b0;
        ev_release = 1'b0;

        if (action == bdlp_pkg::ACT_BEEP) begin
            st_next.beep_left = beep_duration_ms;
            if (beep_duration_ms != '0) begin
                st_next.buzzer = 1'b1;
            end
        end else begin
            hist_next = shifted;
            if (&shifted) begin
                if (!st.pressed) begin
                    st_next.pressed = 1'b1;
                    st_next.hold_count = '0;
                    st_next.long_done = 1'b0;
                end else if (!st.long_done) begin
                    st_next.hold_count = hold_sat;
                    if (hold_sat >= long_press_ms) begin
                        ev_long = 1'b1;
                        st_next.long_done = 1'b1;
                    end
                end else if (st.hold_count < bdlp_pkg::HOLD_CONTINUE_LIMIT) begin
                    st_next.hold_count = hold_sat;
                end
            end else if (shifted == '0 && st.pressed) begin
                st_next.last_hold = st.hold_count;
                ev_release = 1'b1;
                ev_short = !st.long_done;
                st_next.pressed = 1'b0;
                st_next.hold_count = '0;
                st_next.long_done = 1'b0;
            end

            // The beep countdown runs on ticks only and stops at zero.
            if (st.beep_left != '0) begin
                if (st.beep_left <= tick_ext) begin
                    st_next.beep_left = '0;
                    st_next.buzzer = 1'b0;
                end else begin
                    st_next.beep_left = st.beep_left - tick_ext;
                    st_next.buzzer = 1'b1;
                end
            end
        end
    end

    always_comb begin
        result.is_pressed = st_next.pressed;
        result.hold_time_ms = st_next.hold_count;
        result.short_event = ev_short;
        result.long_event = ev_long;
        result.release_event = ev_release;
        result.released_hold_ms = st_next.last_hold;
        result.buzzer_on = st_next.buzzer;
    end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for button_debounce_long_press_beeper: debounce, hold time,
// long/short/release events and the beep countdown are checked against a predictor.
// Depends on bdlp_pkg and the RTL of button_debounce_long_press_beeper.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_W = bdlp_pkg::STABLE_SAMPLES_DEF;
    localparam int HOLD_W = bdlp_pkg::HOLD_W;
    localparam int TICK_W = bdlp_pkg::TICK_W;
    localparam int CFG_ADDR_W = bdlp_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = bdlp_pkg::CFG_DATA_W;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD_OFF = 60;
    localparam int PHASES = 6;
    localparam int PHASE_ITEMS = 58;
    localparam int unsigned PHASE_TICK[PHASES] = '{1000, 1, 37, 0, 250, 3};
    localparam int unsigned PHASE_LONG[PHASES] = '{65535, 0, 250, 5, 2000, 40};

    // Tracks the debounced button, the hold timer and the beeper, and keeps the
    // results that the block still owes in order.
    class press_tracker;
        logic [TICK_W-1:0] tick_ms;
        logic [HOLD_W-1:0] long_ms;
        logic [HIST_W-1:0] history;
        bit                pressed;
        bit                long_done;
        logic [HOLD_W-1:0] hold;
        logic [HOLD_W-1:0] last_hold;
        logic [HOLD_W-1:0] beep_left;
        bit                buzzer;
        bdlp_pkg::result_t owed_results[$];
        int                mismatches;

        function new();
            tick_ms    = bdlp_pkg::TICK_PERIOD_RST;
            long_ms    = bdlp_pkg::LONG_PRESS_RST;
            history    = '0;
            pressed    = 1'b0;
            long_done  = 1'b0;
            hold       = '0;
            last_hold  = '0;
            beep_left  = '0;
            buzzer     = 1'b0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == bdlp_pkg::CFG_TICK_PERIOD) begin
                tick_ms = val[TICK_W-1:0];
            end else if (idx == bdlp_pkg::CFG_LONG_PRESS) begin
                long_ms = val;
            end
        endfunction

        function logic [HOLD_W-1:0] hold_plus_tick();
            logic [HOLD_W:0] sum;
            sum = {1'b0, hold} + HOLD_W'(tick_ms);
            return sum[HOLD_W] ? bdlp_pkg::HOLD_MAX : sum[HOLD_W-1:0];
        endfunction

        function void take_item(logic act, logic raw, logic [HOLD_W-1:0] dur);
            bdlp_pkg::result_t res;
            res = '0;
            if (act == bdlp_pkg::ACT_BEEP) begin
                beep_left = dur;
                if (dur != 0) buzzer = 1'b1;
            end else begin
                history = {history[HIST_W-2:0], raw};
                if (&history) begin
                    if (!pressed) begin
                        pressed   = 1'b1;
                        hold      = '0;
                        long_done = 1'b0;
                    end else if (!long_done) begin
                        hold = hold_plus_tick();
                        if (hold >= long_ms) begin
                            res.long_event = 1'b1;
                            long_done      = 1'b1;
                        end
                    end else if (hold < bdlp_pkg::HOLD_CONTINUE_LIMIT) begin
                        hold = hold_plus_tick();
                    end
                end else if (history == '0 && pressed) begin
                    last_hold         = hold;
                    res.release_event = 1'b1;
                    res.short_event   = !long_done;
                    pressed           = 1'b0;
                    hold              = '0;
                    long_done         = 1'b0;
                end
                if (beep_left != 0) begin
                    if (beep_left <= HOLD_W'(tick_ms)) begin
                        beep_left = '0;
                        buzzer    = 1'b0;
                    end else begin
                        beep_left = beep_left - HOLD_W'(tick_ms);
                        buzzer    = 1'b1;
                    end
                end
            end
            res.is_pressed       = pressed;
            res.hold_time_ms     = hold;
            res.released_hold_ms = last_hold;
            res.buzzer_on        = buzzer;
            owed_results.push_back(res);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(bdlp_pkg::result_t got);
            bdlp_pkg::result_t want;
            if (owed_results.size() == 0) begin
                $error("result transfer with no result outstanding");
                mismatches++;
                return;
            end
            want = owed_results.pop_front();
            check_field("is_pressed", want.is_pressed, got.is_pressed);
            check_field("hold_time_ms", want.hold_time_ms, got.hold_time_ms);
            check_field("short_event", want.short_event, got.short_event);
            check_field("long_event", want.long_event, got.long_event);
            check_field("release_event", want.release_event, got.release_event);
            check_field("released_hold_ms", want.released_hold_ms, got.released_hold_ms);
            check_field("buzzer_on", want.buzzer_on, got.buzzer_on);
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;
    logic                  s_tuser = bdlp_pkg::ACT_TICK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    press_tracker tracker = new();

    int unsigned send_idle_pct = 23;
    int unsigned recv_idle_pct = 79;
    int unsigned hold_off_left = 0;
    bit          hold_off_req = 1'b0;
    bit          hold_off_taken = 1'b0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;

    button_debounce_long_press_beeper i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Result side. A long hold-off is counted here so the sender keeps offering
    // items while the block backs up.
    always @(posedge aclk) begin
        if (hold_off_req && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            hold_off_left  = LONG_HOLD_OFF;
        end
        if (hold_off_left != 0) begin
            hold_off_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) tracker.write_reg(cfg_addr, cfg_data);
            if (s_tvalid && s_tready) tracker.take_item(s_tuser, s_tdata[0], s_tdata[16:1]);
            if (m_tvalid && m_tready) begin
                tracker.check_result(bdlp_pkg::result_t'(m_tdata[bdlp_pkg::RESULT_W-1:0]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("button_debounce_long_press_beeper: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // s_tvalid stays high after a transfer; it drops only in the random idle gaps before an item.
    task automatic send_item(logic act, logic raw, logic [HOLD_W-1:0] dur);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'b0, dur, raw};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic tick(logic raw);
        send_item(bdlp_pkg::ACT_TICK, raw, HOLD_W'($urandom_range(0, 65535)));
    endtask

    task automatic beep(logic [HOLD_W-1:0] dur);
        send_item(bdlp_pkg::ACT_BEEP, 1'($urandom_range(0, 1)), dur);
    endtask

    // Mostly short beeps so the buzzer turns off again within a press.
    task automatic tick_with_beep(logic raw);
        if ($urandom_range(99) < 8) begin
            case ($urandom_range(0, 7))
                0, 1:    beep('0);
                2:       beep(bdlp_pkg::HOLD_MAX);
                3, 4:    beep(HOLD_W'($urandom_range(0, 65535)));
                default: beep(HOLD_W'($urandom_range(1, 3 * tracker.tick_ms + 1)));
            endcase
        end
        tick(raw);
    endtask

    // Bounce, a stable press with rare glitches, bounce again, then a stable release.
    task automatic press_sequence(int unsigned held);
        int unsigned n;
        n = $urandom_range(0, 3);
        repeat (n) tick_with_beep(1'($urandom_range(0, 1)));
        repeat (HIST_W + held) tick_with_beep($urandom_range(99) >= 4);
        n = $urandom_range(0, 3);
        repeat (n) tick_with_beep(1'($urandom_range(0, 1)));
        n = $urandom_range(HIST_W, HIST_W + 2);
        repeat (n) tick_with_beep(1'b0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_config(int unsigned tick_period, int unsigned long_press);
        write_reg(bdlp_pkg::CFG_TICK_PERIOD, CFG_DATA_W'(tick_period));
        write_reg(bdlp_pkg::CFG_LONG_PRESS, CFG_DATA_W'(long_press));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned items_target;
        int unsigned n;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: press, hold, beep extremes, short release, idle countdown.
        repeat (6) tick(1'b1);
        send_item(bdlp_pkg::ACT_BEEP, 1'b1, bdlp_pkg::HOLD_MAX);
        send_item(bdlp_pkg::ACT_BEEP, 1'b0, '0);
        repeat (5) tick(1'b0);
        beep(HOLD_W'(15));
        repeat (3) tick(1'b0);

        // Zero tick period with a zero limit: long event on the first held tick,
        // frozen hold time and countdown, release without a short event.
        drain();
        set_config(0, 0);
        repeat (5) tick(1'b1);
        beep(HOLD_W'(5));
        tick(1'b1);
        repeat (4) tick(1'b0);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_config(PHASE_TICK[p], PHASE_LONG[p]);
            send_idle_pct = (p < 2) ? 23 : (p < 4) ? 79 : 0;
            recv_idle_pct = (p < 2) ? 79 : (p < 4) ? 23 : 0;
            if (p == 1) hold_off_req = 1'b1;
            items_target = items_sent + PHASE_ITEMS;
            while (items_sent < items_target) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        n = $urandom_range(1, 8);
                        repeat (n) tick_with_beep(1'($urandom_range(0, 1)));
                    end
                    2:       press_sequence($urandom_range(20, 80));
                    default: press_sequence($urandom_range(0, 12));
                endcase
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("button_debounce_long_press_beeper: match");
        end else begin
            $display("button_debounce_long_press_beeper: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
